// File: src/lkv_pkg.sv
`default_nettype none
package lkv_pkg;

    localparam int STORE_DEPTH = 8;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    // ranks run 0 .. STORE_DEPTH, the top value marks an insert into a free slot
    localparam int RANK_W = $clog2(STORE_DEPTH + 1);
    localparam int OCC_W  = $clog2(STORE_DEPTH + 1);
    localparam int CAP_W  = 4;
    localparam int STAT_W = 3;
    localparam int READ_W = 32;
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_GET_HIT      = 3'd0,
        ST_GET_MISS     = 3'd1,
        ST_PUT_UPDATED  = 3'd2,
        ST_PUT_INSERTED = 3'd3,
        ST_PUT_EVICTED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    // search results gathered as the token walks down the row of cells
    typedef struct packed {
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [RANK_W-1:0]     hit_rank;
        logic [VALUE_BITS-1:0] hit_value;
        logic                  free_ok;
        logic [IDX_W-1:0]      free_idx;
        logic                  lru_ok;
        logic [IDX_W-1:0]      lru_idx;
        logic [RANK_W-1:0]     lru_rank;
    } t_tok;

    // update broadcast to every cell once the search is over
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [RANK_W-1:0] old_rank;
        logic              wr_key;
        logic              wr_value;
        logic              set_valid;
    } t_cmd;

endpackage
`default_nettype wire

// File: src/lru_key_value_cache_core.sv
`default_nettype none
// a search token walks the row of cells one cell per cycle before the update is broadcast;
//   no new item is accepted until the update for the last one has been applied
// the next item may be accepted while a finished result still waits on the output
// reset (synchronous, i_rst_n low) clears valid marks, ranks, occupancy and the
//   result valid flag, and sets capacity_limit to 8; keys and values are not cleared
module lru_key_value_cache_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_operation,
    input  wire  [lkv_pkg::KEY_BITS-1:0]   i_key,
    input  wire  [lkv_pkg::VALUE_BITS-1:0] i_value,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [lkv_pkg::STAT_W-1:0]     o_status,
    output logic [lkv_pkg::READ_W-1:0]     o_read_value,
    input  wire                            i_cfg_we,
    input  wire  [lkv_pkg::CAP_W-1:0]      i_cfg_data
);
    import lkv_pkg::*;

    logic                  w_inject;
    logic [KEY_BITS-1:0]   w_key;
    logic [VALUE_BITS-1:0] w_value;
    t_cmd                  w_cmd;
    logic                  w_tok_valid [STORE_DEPTH+1];
    t_tok                  w_tok       [STORE_DEPTH+1];

    // fresh token enters the first cell with nothing found yet
    assign w_tok_valid[0] = w_inject;
    assign w_tok[0]       = '0;

    lkv_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_inject     (w_inject),
        .o_key        (w_key),
        .o_value      (w_value),
        .o_cmd        (w_cmd),
        .i_last_valid (w_tok_valid[STORE_DEPTH]),
        .i_last_tok   (w_tok[STORE_DEPTH])
    );

    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        lkv_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_idx       (IDX_W'(g)),
            .i_tok_valid (w_tok_valid[g]),
            .i_tok       (w_tok[g]),
            .i_key       (w_key),
            .i_value     (w_value),
            .i_cmd       (w_cmd),
            .o_tok_valid (w_tok_valid[g+1]),
            .o_tok       (w_tok[g+1])
        );
    end

endmodule
`default_nettype wire

// File: src/lkv_cell.sv
`default_nettype none
module lkv_cell (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  [lkv_pkg::IDX_W-1:0]     i_idx,
    input  wire                           i_tok_valid,
    input  lkv_pkg::t_tok                 i_tok,
    input  wire  [lkv_pkg::KEY_BITS-1:0]  i_key,
    input  wire  [lkv_pkg::VALUE_BITS-1:0] i_value,
    input  lkv_pkg::t_cmd                 i_cmd,
    output logic                          o_tok_valid,
    output lkv_pkg::t_tok                 o_tok
);
    import lkv_pkg::*;

    logic                  r_valid;
    logic [RANK_W-1:0]     r_rank;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_tok_valid;
    t_tok                  r_tok;
    t_tok                  n_tok;

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && r_valid && (r_key == i_key)) begin
            n_tok.hit       = 1'b1;
            n_tok.hit_idx   = i_idx;
            n_tok.hit_rank  = r_rank;
            n_tok.hit_value = r_value;
        end
        if (!i_tok.free_ok && !r_valid) begin
            n_tok.free_ok  = 1'b1;
            n_tok.free_idx = i_idx;
        end
        // ties go to the later cell
        if (r_valid && (!i_tok.lru_ok || (r_rank >= i_tok.lru_rank))) begin
            n_tok.lru_ok   = 1'b1;
            n_tok.lru_idx  = i_idx;
            n_tok.lru_rank = r_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_valid) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_cmd.en) begin
            if (i_cmd.idx == i_idx) begin
                r_rank <= '0;
                if (i_cmd.set_valid) begin
                    r_valid <= 1'b1;
                end
            end else if (r_valid && (r_rank < i_cmd.old_rank)) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en && (i_cmd.idx == i_idx)) begin
            if (i_cmd.wr_key) begin
                r_key <= i_key;
            end
            if (i_cmd.wr_value) begin
                r_value <= i_value;
            end
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule
`default_nettype wire

// File: src/lkv_ctrl.sv
`default_nettype none
module lkv_ctrl (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_operation,
    input  wire  [lkv_pkg::KEY_BITS-1:0]   i_key,
    input  wire  [lkv_pkg::VALUE_BITS-1:0] i_value,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [lkv_pkg::STAT_W-1:0]     o_status,
    output logic [lkv_pkg::READ_W-1:0]     o_read_value,
    input  wire                            i_cfg_we,
    input  wire  [lkv_pkg::CAP_W-1:0]      i_cfg_data,
    output logic                           o_inject,
    output logic [lkv_pkg::KEY_BITS-1:0]   o_key,
    output logic [lkv_pkg::VALUE_BITS-1:0] o_value,
    output lkv_pkg::t_cmd                  o_cmd,
    input  wire                            i_last_valid,
    input  lkv_pkg::t_tok                  i_last_tok
);
    import lkv_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic                  r_inject;
    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [OCC_W-1:0]      r_occ;
    logic [CAP_W-1:0]      r_cap;
    logic                  r_out_valid;
    t_status               r_status;
    logic [READ_W-1:0]     r_rd;

    logic                  accept;
    logic                  apply_go;
    logic [CMP_W-1:0]      cap_eff;
    logic                  room;
    t_status               dec_status;
    logic [READ_W-1:0]     dec_rd;
    t_cmd                  dec_cmd;

    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_last_valid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (apply_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        apply_go   = 1'b0;
        case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_SCAN:  o_in_stall = 1'b1;
            // the result register may still hold the previous result
            S_APPLY: apply_go = !r_out_valid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_comb begin
        cap_eff = CMP_W'(r_cap);
        if (cap_eff == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_eff > CMP_W'(STORE_DEPTH)) begin
            cap_eff = CMP_W'(STORE_DEPTH);
        end
        room = (CMP_W'(r_occ) < cap_eff) && i_last_tok.free_ok;
    end

    always_comb begin
        dec_status       = ST_GET_MISS;
        dec_rd           = '0;
        dec_cmd          = '0;
        dec_cmd.idx      = i_last_tok.hit_idx;
        dec_cmd.old_rank = i_last_tok.hit_rank;
        if (r_op == OP_GET) begin
            if (i_last_tok.hit) begin
                dec_status = ST_GET_HIT;
                dec_rd     = READ_W'(i_last_tok.hit_value);
                dec_cmd.en = 1'b1;
            end
        end else if (i_last_tok.hit) begin
            dec_status       = ST_PUT_UPDATED;
            dec_cmd.en       = 1'b1;
            dec_cmd.wr_value = 1'b1;
        end else if (room) begin
            dec_status        = ST_PUT_INSERTED;
            dec_cmd.en        = 1'b1;
            dec_cmd.idx       = i_last_tok.free_idx;
            dec_cmd.old_rank  = RANK_W'(STORE_DEPTH);
            dec_cmd.wr_key    = 1'b1;
            dec_cmd.wr_value  = 1'b1;
            dec_cmd.set_valid = 1'b1;
        end else begin
            dec_status       = ST_PUT_EVICTED;
            dec_cmd.en       = 1'b1;
            dec_cmd.idx      = i_last_tok.lru_ok ? i_last_tok.lru_idx : '0;
            dec_cmd.old_rank = i_last_tok.lru_ok ? i_last_tok.lru_rank : '0;
            dec_cmd.wr_key   = 1'b1;
            dec_cmd.wr_value = 1'b1;
        end
        dec_cmd.en = dec_cmd.en && apply_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_occ       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= accept;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (apply_go && (dec_status == ST_PUT_INSERTED)) begin
                r_occ <= r_occ + 1'b1;
            end
            if (apply_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (apply_go) begin
            r_status <= dec_status;
            r_rd     <= dec_rd;
        end
    end

    assign o_inject     = r_inject;
    assign o_key        = r_key;
    assign o_value      = r_value;
    assign o_cmd        = dec_cmd;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rd;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_occ) <= CMP_W'(STORE_DEPTH))
        else $error("occupancy above store depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_out_valid && i_out_stall) |=> (r_state == S_APPLY))
        else $error("result register overwritten while stalled");

    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_last_valid |-> (r_state == S_SCAN))
        else $error("search token left the row outside a search");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply_go && dec_status == ST_PUT_INSERTED)
            |=> (r_occ == OCC_W'($past(r_occ) + 1'b1)))
        else $error("insert did not raise occupancy");
`endif

endmodule
`default_nettype wire
